// ----- rtl/first_fit_hole_allocator_core_macros.svh -----
// Assertion macros for the first-fit hole allocator.
// Checks compile away when SYNTH is defined.
`ifndef FIRST_FIT_HOLE_ALLOCATOR_CORE_MACROS_SVH
`define FIRST_FIT_HOLE_ALLOCATOR_CORE_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, disabled during reset
`define FFHA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ffha assertion failed");
// Next-cycle implication, disabled during reset
`define FFHA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ffha assertion failed");
`else
`define FFHA_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define FFHA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/ffha_pkg.sv -----
package ffha_pkg;

	// Fixed field widths of the stream payload
	localparam int FIELD_IDX_W  = 4;
	localparam int FIELD_SIZE_W = 16;
	localparam int COUNT_W      = 5;
	localparam int TDATA_W      = 24;

	// Request kinds carried on s_tuser
	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_ALLOC = 1'b1;

	// Control sequencer states
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} state_t;

endpackage

// ----- rtl/ffha_ram.sv -----
module ffha_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/first_fit_hole_allocator_core.sv -----
// First-fit hole allocator. A load request (s_tuser low) writes one hole's size into
// the hole RAM; an allocate request (s_tuser high) scans holes from index zero up to
// min(hole_count, MAX_HOLES)-1 and takes the first whose remaining size covers the
// request, subtracts the request and reports the hole and its new size, or reports
// not found and leaves all holes unchanged. Every request gives exactly one result.
// A load passes from acceptance through ST_DONE back to ST_IDLE; an allocate with
// holes in use first passes through ST_SCAN, which examines the holes in turn (at
// most MAX_HOLES) since the single read port of the hole RAM delivers one hole per
// cycle. Results wait in an output register, so a new request is taken while the
// last result is unread. Holes never loaded read back undefined sizes.
`include "first_fit_hole_allocator_core_macros.svh"

module first_fit_hole_allocator_core #(
	parameter int MAX_HOLES = 16,
	parameter int SIZE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Hole count register
	input  logic                          cfg_we,
	input  logic [ffha_pkg::COUNT_W-1:0]  cfg_wdata,
	// Requests
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [ffha_pkg::TDATA_W-1:0]  s_tdata,  // hole_index[3:0], size[19:4], zero pad
	input  logic                          s_tuser,  // cmd
	// Results
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [ffha_pkg::TDATA_W-1:0]  m_tdata,  // hole_number[3:0], remaining[19:4], zero pad
	output logic                          m_tuser   // found
);

	import ffha_pkg::*;

	localparam int IDX_W = $clog2(MAX_HOLES);
	localparam int CNT_W = $clog2(MAX_HOLES + 1);

	state_t                  state_q;
	logic [COUNT_W-1:0]      hole_count_q;
	logic [IDX_W-1:0]        chk_ptr_q;
	logic [SIZE_BITS-1:0]    req_q;
	logic                    res_found_q;
	logic [FIELD_IDX_W-1:0]  res_idx_q;
	logic [FIELD_SIZE_W-1:0] res_rem_q;
	logic                    m_valid_q;
	logic                    m_found_q;
	logic [FIELD_IDX_W-1:0]  m_idx_q;
	logic [FIELD_SIZE_W-1:0] m_rem_q;

	logic [FIELD_IDX_W-1:0]  in_idx;
	logic [FIELD_SIZE_W-1:0] in_size;
	logic [SIZE_BITS-1:0]    in_sz;
	logic                    in_acc;
	logic                    load_ok;
	logic [CNT_W-1:0]        limit;
	logic [CNT_W-1:0]        next_cnt;
	logic                    fit;
	logic                    last_hole;
	logic                    out_free;

	logic                    ram_we;
	logic [IDX_W-1:0]        ram_waddr;
	logic [SIZE_BITS-1:0]    ram_wdata;
	logic                    ram_re;
	logic [IDX_W-1:0]        ram_raddr;
	logic [SIZE_BITS-1:0]    ram_rdata;

	// Unpack the request and derive scan bounds
	assign in_idx    = s_tdata[FIELD_IDX_W-1:0];
	assign in_size   = s_tdata[FIELD_IDX_W+FIELD_SIZE_W-1:FIELD_IDX_W];
	assign in_sz     = SIZE_BITS'(in_size);
	assign s_tready  = (state_q == ST_IDLE);
	assign in_acc    = s_tvalid && s_tready;
	assign load_ok   = (32'(in_idx) < MAX_HOLES);
	assign limit     = (32'(hole_count_q) > MAX_HOLES) ? CNT_W'(MAX_HOLES)
	                                                   : CNT_W'(hole_count_q);
	assign next_cnt  = CNT_W'(chk_ptr_q) + CNT_W'(1);
	assign fit       = (req_q <= ram_rdata);
	assign last_hole = (next_cnt == limit);
	assign out_free  = !m_valid_q || m_tready;

	// Hole RAM access: load writes at acceptance, allocate writes back on a fit
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = IDX_W'(in_idx);
		ram_wdata = in_sz;
		ram_re    = 1'b0;
		ram_raddr = '0;
		if (state_q == ST_IDLE) begin
			ram_we = in_acc && (s_tuser == CMD_LOAD) && load_ok;
			ram_re = in_acc && (s_tuser == CMD_ALLOC);
		end else if (state_q == ST_SCAN) begin
			ram_we    = fit;
			ram_waddr = chk_ptr_q;
			ram_wdata = ram_rdata - req_q;
			ram_re    = !fit && !last_hole;
			ram_raddr = IDX_W'(next_cnt);
		end
	end

	ffha_ram #(
		.WIDTH (SIZE_BITS),
		.DEPTH (MAX_HOLES)
	) u_hole_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Hold the hole count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hole_count_q <= '0;
		end else if (cfg_we) begin
			hole_count_q <= cfg_wdata;
		end
	end

	// Sequence: accept, scan one hole per cycle (allocates with holes in use only), hand the result over
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (s_tuser == CMD_ALLOC && limit != '0) begin
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_SCAN: begin
					if (fit || last_hole) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Capture the request and build the pending result
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_acc) begin
			req_q     <= in_sz;
			chk_ptr_q <= '0;
			if (s_tuser == CMD_LOAD) begin
				res_found_q <= load_ok;
				res_idx_q   <= in_idx;
				res_rem_q   <= load_ok ? FIELD_SIZE_W'(in_sz) : '0;
			end else begin
				res_found_q <= 1'b0;
				res_idx_q   <= '0;
				res_rem_q   <= '0;
			end
		end else if (state_q == ST_SCAN) begin
			if (fit) begin
				res_found_q <= 1'b1;
				res_idx_q   <= FIELD_IDX_W'(chk_ptr_q);
				res_rem_q   <= FIELD_SIZE_W'(ram_rdata - req_q);
			end else begin
				chk_ptr_q <= IDX_W'(next_cnt);
			end
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			m_found_q <= res_found_q;
			m_idx_q   <= res_idx_q;
			m_rem_q   <= res_rem_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_found_q;
	assign m_tdata  = {(TDATA_W-FIELD_IDX_W-FIELD_SIZE_W)'(0), m_rem_q, m_idx_q};

	// Scan pointer stays inside the holes in use
	`FFHA_ASSERT_NOW(a_scan_in_range, clk, arst_n, state_q == ST_SCAN, next_cnt <= limit)
	// A write-back during the scan ends it
	`FFHA_ASSERT_NEXT(a_fit_ends_scan, clk, arst_n, state_q == ST_SCAN && ram_we, state_q == ST_DONE)
	// A finished result lands in the output register
	`FFHA_ASSERT_NEXT(a_result_lands, clk, arst_n, state_q == ST_DONE && out_free, m_tvalid)

endmodule

// ----- tb/sv/tb_first_fit_hole_allocator_core.sv -----
`timescale 1ns / 100ps

module tb_first_fit_hole_allocator_core;
	import ffha_pkg::*;

	localparam int HOLES           = 16;
	localparam int RANDOM_REQUESTS = 850;
	localparam int GAP_MAX         = 17;
	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int REPORT_MAX      = 10;
	localparam int TAIL_CYCLES     = 40;
	localparam int PAD_W           = TDATA_W - FIELD_SIZE_W - FIELD_IDX_W;

	typedef struct packed {
		logic                    found;
		logic [FIELD_IDX_W-1:0]  hole;
		logic [FIELD_SIZE_W-1:0] left;
	} alloc_result_t;

	typedef enum bit {ROW_SET_COUNT, ROW_REQUEST} row_kind_t;

	typedef struct packed {
		row_kind_t               kind;
		logic [COUNT_W-1:0]      count;
		logic                    cmd;
		logic [FIELD_IDX_W-1:0]  hole;
		logic [FIELD_SIZE_W-1:0] size;
		bit                      typed;
		alloc_result_t           result;
	} plan_row_t;

	localparam alloc_result_t NO_FIT = '0;
	localparam int PLAN_LEN = 19;

	// Directed opening; typed results only where they are obvious
	localparam plan_row_t DIRECTED_PLAN [PLAN_LEN] = '{
		'{ROW_SET_COUNT, 5'd0, CMD_LOAD,  4'd0,  16'h0000, 1'b0, NO_FIT},
		// no holes in use: nothing can fit, not even a zero request
		'{ROW_REQUEST,   5'd0, CMD_ALLOC, 4'd0,  16'd100,  1'b1, NO_FIT},
		'{ROW_REQUEST,   5'd0, CMD_ALLOC, 4'hF,  16'h0000, 1'b1, NO_FIT},
		// loads echo index and size
		'{ROW_REQUEST,   5'd0, CMD_LOAD,  4'd0,  16'hFFFF, 1'b1, '{1'b1, 4'd0,  16'hFFFF}},
		'{ROW_REQUEST,   5'd0, CMD_LOAD,  4'd1,  16'h0000, 1'b1, '{1'b1, 4'd1,  16'h0000}},
		'{ROW_REQUEST,   5'd0, CMD_LOAD,  4'd2,  16'h0005, 1'b1, '{1'b1, 4'd2,  16'h0005}},
		'{ROW_REQUEST,   5'd0, CMD_LOAD,  4'd15, 16'hA5A5, 1'b1, '{1'b1, 4'd15, 16'hA5A5}},
		'{ROW_SET_COUNT, 5'd3, CMD_LOAD,  4'd0,  16'h0000, 1'b0, NO_FIT},
		// zero request takes the first hole, then drain it fully
		'{ROW_REQUEST,   5'd0, CMD_ALLOC, 4'd7,  16'h0000, 1'b0, NO_FIT},
		'{ROW_REQUEST,   5'd0, CMD_ALLOC, 4'd0,  16'hFFFF, 1'b0, NO_FIT},
		// zero request still fits an empty first hole
		'{ROW_REQUEST,   5'd0, CMD_ALLOC, 4'd0,  16'h0000, 1'b0, NO_FIT},
		// exact fit further along the table
		'{ROW_REQUEST,   5'd0, CMD_ALLOC, 4'hF,  16'h0005, 1'b0, NO_FIT},
		'{ROW_REQUEST,   5'd0, CMD_ALLOC, 4'd0,  16'h0001, 1'b1, NO_FIT},
		'{ROW_REQUEST,   5'd0, CMD_LOAD,  4'd1,  16'h00FF, 1'b1, '{1'b1, 4'd1,  16'h00FF}},
		'{ROW_REQUEST,   5'd0, CMD_ALLOC, 4'd0,  16'h0010, 1'b0, NO_FIT},
		'{ROW_REQUEST,   5'd0, CMD_ALLOC, 4'd0,  16'hFFFF, 1'b1, NO_FIT},
		'{ROW_SET_COUNT, 5'd1, CMD_LOAD,  4'd0,  16'h0000, 1'b0, NO_FIT},
		'{ROW_REQUEST,   5'd0, CMD_ALLOC, 4'd0,  16'h0000, 1'b0, NO_FIT},
		'{ROW_REQUEST,   5'd0, CMD_ALLOC, 4'd0,  16'h0001, 1'b1, NO_FIT}
	};

	// Hole counts for the first random phases; later ones are drawn
	localparam int ANCHOR_LEN = 7;
	localparam logic [COUNT_W-1:0] ANCHOR_COUNTS [ANCHOR_LEN] = '{
		5'd16, 5'd31, 5'd0, 5'd1, 5'd17, 5'd2, 5'd15
	};

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_we;
	logic [COUNT_W-1:0]  cfg_wdata;
	logic                s_tvalid;
	logic                s_tready;
	logic [TDATA_W-1:0]  s_tdata;   // hole_index[3:0], size[19:4], zero pad
	logic                s_tuser;   // cmd
	logic                m_tvalid;
	logic                m_tready;
	logic [TDATA_W-1:0]  m_tdata;   // hole_number[3:0], remaining[19:4], zero pad
	logic                m_tuser;   // found

	// Shadow of the hole table and the count register
	logic [FIELD_SIZE_W-1:0] hole_left [HOLES];
	bit                      hole_loaded [HOLES];
	logic [COUNT_W-1:0]      holes_in_use;
	alloc_result_t           pending_results [$];

	bit no_idling;
	int idle_cycles;
	int loads_sent, allocs_sent, count_writes;
	int results_seen, grants_seen, misses_seen, fault_count;

	first_fit_hole_allocator_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Apply one request to the shadow table and return its result
	function automatic alloc_result_t first_fit(input logic cmd,
			input logic [FIELD_IDX_W-1:0] hole, input logic [FIELD_SIZE_W-1:0] size);
		alloc_result_t r;
		int scan_end;
		r = NO_FIT;
		if (cmd == CMD_LOAD) begin
			hole_left[hole] = size;
			hole_loaded[hole] = 1'b1;
			r.found = 1'b1;
			r.hole = hole;
			r.left = size;
			return r;
		end
		// counts above the table size saturate
		scan_end = (holes_in_use > HOLES) ? HOLES : int'(holes_in_use);
		for (int j = 0; j < scan_end; j++) begin
			if (size <= hole_left[j]) begin
				hole_left[j] = hole_left[j] - size;
				r.found = 1'b1;
				r.hole = FIELD_IDX_W'(j);
				r.left = hole_left[j];
				return r;
			end
		end
		return r;
	endfunction

	// Wait a random gap (none while no_idling is set), offer one request, record its result on acceptance
	task automatic send_request(input logic cmd, input logic [FIELD_IDX_W-1:0] hole,
			input logic [FIELD_SIZE_W-1:0] size, input bit typed,
			input alloc_result_t typed_result);
		int gap;
		alloc_result_t predicted;
		gap = no_idling ? 0 : $urandom_range(0, GAP_MAX);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {{PAD_W{1'b0}}, size, hole};
		do @(posedge clk); while (!(s_tvalid && s_tready));
		predicted = first_fit(cmd, hole, size);
		pending_results.push_back(typed ? typed_result : predicted);
		if (cmd == CMD_LOAD)
			loads_sent++;
		else
			allocs_sent++;
	endtask

	// Drop the request line and hold until every result has been taken
	task automatic settle_requests;
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// Write the hole count once the block is idle
	task automatic set_hole_count(input logic [COUNT_W-1:0] value);
		settle_requests();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		holes_in_use = value;
		count_writes++;
	endtask

	// Result side: random stall before each result, none while no_idling is set
	initial begin : result_stall
		int stall;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = no_idling ? 0 : $urandom_range(0, GAP_MAX);
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
		end
	end

	// Compare each result with the oldest outstanding one
	always @(posedge clk) begin : result_check
		alloc_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (m_tuser)
				grants_seen++;
			else
				misses_seen++;
			if (pending_results.size() == 0) begin
				fault_count++;
				if (fault_count <= REPORT_MAX)
					$display("result %0d arrived with none outstanding: found=%0b data=%h",
						results_seen, m_tuser, m_tdata);
			end else begin
				want = pending_results.pop_front();
				if (m_tuser !== want.found ||
						m_tdata[FIELD_IDX_W-1:0] !== want.hole ||
						m_tdata[FIELD_IDX_W+FIELD_SIZE_W-1:FIELD_IDX_W] !== want.left) begin
					fault_count++;
					if (fault_count <= REPORT_MAX)
						$display("result %0d: expected found=%0b hole=%0d left=%h, got found=%0b hole=%0d left=%h",
							results_seen, want.found, want.hole, want.left, m_tuser,
							m_tdata[FIELD_IDX_W-1:0],
							m_tdata[FIELD_IDX_W+FIELD_SIZE_W-1:FIELD_IDX_W]);
				end
			end
		end
	end

	// End the run if no handshake happens for too long
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles, %0d results outstanding",
					idle_cycles, pending_results.size());
				$display("tb_first_fit_hole_allocator_core: done, errors");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int random_sent;
		int phase;
		int scan_end;
		int phase_len;
		int pick;
		logic [COUNT_W-1:0]      next_count;
		logic                    cmd;
		logic [FIELD_IDX_W-1:0]  hole;
		logic [FIELD_SIZE_W-1:0] size;
		logic [FIELD_SIZE_W-1:0] target;

		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= CMD_LOAD;
		no_idling = 1'b0;
		holes_in_use = '0;
		idle_cycles = 0;
		for (int j = 0; j < HOLES; j++) begin
			hole_left[j] = '0;
			hole_loaded[j] = 1'b0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table
		for (int i = 0; i < PLAN_LEN; i++) begin
			if (DIRECTED_PLAN[i].kind == ROW_SET_COUNT)
				set_hole_count(DIRECTED_PLAN[i].count);
			else
				send_request(DIRECTED_PLAN[i].cmd, DIRECTED_PLAN[i].hole,
					DIRECTED_PLAN[i].size, DIRECTED_PLAN[i].typed,
					DIRECTED_PLAN[i].result);
		end

		// Random phases, each under its own hole count
		random_sent = 0;
		phase = 0;
		while (random_sent < RANDOM_REQUESTS) begin
			next_count = (phase < ANCHOR_LEN) ? ANCHOR_COUNTS[phase] :
				COUNT_W'($urandom_range(0, 31));
			set_hole_count(next_count);
			no_idling = (phase % 3 == 2);
			scan_end = (next_count > HOLES) ? HOLES : int'(next_count);

			// load every hole the scan can reach before any allocate
			for (int j = 0; j < scan_end; j++) begin
				if (!hole_loaded[j]) begin
					send_request(CMD_LOAD, FIELD_IDX_W'(j), FIELD_SIZE_W'($urandom),
						1'b0, NO_FIT);
					random_sent++;
				end
			end

			phase_len = $urandom_range(40, 90);
			repeat (phase_len) begin
				pick = $urandom_range(0, 99);
				hole = FIELD_IDX_W'($urandom);
				if (pick < 30) begin
					cmd = CMD_LOAD;
					case ($urandom_range(0, 3))
						0: size = '0;
						1: size = '1;
						2: size = FIELD_SIZE_W'($urandom_range(0, 255));
						default: size = FIELD_SIZE_W'($urandom);
					endcase
				end else begin
					cmd = CMD_ALLOC;
					pick = $urandom_range(0, 9);
					if (pick == 0) begin
						size = '0;
					end else if (pick == 1) begin
						size = '1;
					end else if (pick <= 3 && scan_end > 0) begin
						// exact fit, or one more than a hole holds
						target = hole_left[$urandom_range(0, scan_end - 1)];
						size = (pick == 2) ? target : target + 1'b1;
					end else if (pick <= 6) begin
						size = FIELD_SIZE_W'($urandom_range(1, 'hFFF));
					end else begin
						size = FIELD_SIZE_W'($urandom);
					end
				end
				send_request(cmd, hole, size, 1'b0, NO_FIT);
				random_sent++;
			end
			phase++;
		end

		// Drain and let the block run out
		settle_requests();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d loads and %0d allocates over %0d hole-count writes",
			loads_sent, allocs_sent, count_writes);
		$display("%0d results: %0d granted or loaded, %0d not found; %0d mismatches",
			results_seen, grants_seen, misses_seen, fault_count);
		if (fault_count == 0 && pending_results.size() == 0)
			$display("tb_first_fit_hole_allocator_core: done, clean");
		else
			$display("tb_first_fit_hole_allocator_core: done, errors");
		$finish;
	end

endmodule
